// ----- hdl/vertex_transform_4x4_defines.svh -----
// Assertion macros for the vertex transform block.
// Used by the top level; needs clk and rst_n in scope.
`ifndef VERTEX_TRANSFORM_4X4_DEFINES_SVH
`define VERTEX_TRANSFORM_4X4_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define VT4_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex_transform_4x4 check failed");

// Check that cons holds in the cycle after ante.
`define VT4_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex_transform_4x4 check failed");

`endif

// ----- hdl/vt4_pkg.sv -----
// Types and constants for the vertex transform block.
// No dependencies; used by every other source file but the defines header.
package vt4_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int DIM       = 4;
    localparam int ELEMS     = DIM * DIM;
    localparam int IDX_W     = $clog2(ELEMS);
    localparam int PROD_W    = 2 * WORD_W;
    localparam int TERM_W    = PROD_W - FRAC_BITS;
    localparam int PAIR_W    = TERM_W + 1;
    localparam int SUM_W     = TERM_W + 2;

    localparam logic MODE_LOAD      = 1'b0;
    localparam logic MODE_TRANSFORM = 1'b1;

    localparam logic signed [WORD_W-1:0] ONE_Q = WORD_W'(1) << FRAC_BITS;

    typedef logic signed [WORD_W-1:0] vt4_word_t;
    typedef logic signed [PROD_W-1:0] vt4_prod_t;
    typedef logic signed [TERM_W-1:0] vt4_term_t;
    typedef logic signed [PAIR_W-1:0] vt4_pair_t;
    typedef logic signed [SUM_W-1:0]  vt4_sum_t;

    typedef struct packed {
        logic en_mul;
        logic en_pair;
        logic en_sum;
    } vt4_lane_ctrl_t;

endpackage

// ----- hdl/vt4_if.sv -----
// Channel interfaces: input item and result item with valid/ready.
// Depends on vt4_pkg.
interface vt4_in_if;
    logic                       valid;
    logic                       ready;
    logic                       mode;
    logic [vt4_pkg::IDX_W-1:0]  elem_index;
    vt4_pkg::vt4_word_t         elem_value;
    vt4_pkg::vt4_word_t         vec_x;
    vt4_pkg::vt4_word_t         vec_y;
    vt4_pkg::vt4_word_t         vec_z;
    vt4_pkg::vt4_word_t         vec_w;

    modport source (output valid, mode, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
                    input ready);
    modport sink   (input valid, mode, elem_index, elem_value, vec_x, vec_y, vec_z, vec_w,
                    output ready);
endinterface

interface vt4_out_if;
    logic                valid;
    logic                ready;
    vt4_pkg::vt4_word_t  out_x;
    vt4_pkg::vt4_word_t  out_y;
    vt4_pkg::vt4_word_t  out_z;
    vt4_pkg::vt4_word_t  out_w;
    logic                sat_flag;

    modport source (output valid, out_x, out_y, out_z, out_w, sat_flag, input ready);
    modport sink   (input valid, out_x, out_y, out_z, out_w, sat_flag, output ready);
endinterface

// ----- hdl/vertex_transform_4x4.sv -----
// Pipeline: multiply at the input transfer, then pair sum, final sum with saturation,
// output register. Throughput: one item per cycle; each stage holds only while the
// stage after it is full and stalled.
// Load items update the matrix at their transfer and leave no trace in the pipe.
// Reset: matrix to identity in Q16.16, all pipeline stages empty.
// Depends on vt4_pkg, vt4_if, vt4_lane, vt4_merge and the defines header.
`include "vertex_transform_4x4_defines.svh"

module vertex_transform_4x4 (
    input  logic       clk,
    input  logic       rst_n,
    vt4_in_if.sink     in_item,
    vt4_out_if.source  out_item
);
    import vt4_pkg::*;

    vt4_word_t mat_reg [ELEMS];
    logic      v1_reg, v2_reg, v3_reg;
    logic      v1_next, v2_next, v3_next;
    logic      rdy1, rdy2, rdy3, rdy4;
    logic      in_xfer;

    vt4_lane_ctrl_t ctrl;
    vt4_word_t      vec [DIM];
    vt4_word_t      lane_sum [DIM];
    logic [DIM-1:0] lane_sat;

    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign in_item.ready = rdy1;
    assign in_xfer = in_item.valid && rdy1;

    always_comb
    begin
        v1_next = rdy1 ? (in_xfer && (in_item.mode == MODE_TRANSFORM)) : v1_reg;
        v2_next = rdy2 ? v1_reg : v2_reg;
        v3_next = rdy3 ? v2_reg : v3_reg;
        ctrl.en_mul  = in_xfer && (in_item.mode == MODE_TRANSFORM);
        ctrl.en_pair = rdy2 && v1_reg;
        ctrl.en_sum  = rdy3 && v2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int i = 0; i < ELEMS; i++)
            begin
                mat_reg[i] <= ((i % (DIM + 1)) == 0) ? ONE_Q : '0;
            end
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            if (in_xfer && (in_item.mode == MODE_LOAD))
            begin
                mat_reg[in_item.elem_index] <= in_item.elem_value;
            end
        end
    end

    assign vec[0] = in_item.vec_x;
    assign vec[1] = in_item.vec_y;
    assign vec[2] = in_item.vec_z;
    assign vec[3] = in_item.vec_w;

    for (genvar r = 0; r < DIM; r++)
    begin : g_lane
        vt4_word_t row [DIM];
        for (genvar c = 0; c < DIM; c++)
        begin : g_col
            assign row[c] = mat_reg[c * DIM + r];
        end
        vt4_lane u_lane (
            .clk  (clk),
            .ctrl (ctrl),
            .row  (row),
            .vec  (vec),
            .sum  (lane_sum[r]),
            .sat  (lane_sat[r])
        );
    end

    vt4_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v3_reg),
        .up_ready (rdy4),
        .lane_sum (lane_sum),
        .lane_sat (lane_sat),
        .out_item (out_item)
    );

    `VT4_ASSERT_NEXT(a_load_no_result, in_xfer && (in_item.mode == MODE_LOAD), !v1_reg)
    `VT4_ASSERT_NEXT(a_xform_enters, in_xfer && (in_item.mode == MODE_TRANSFORM), v1_reg)
    `VT4_ASSERT_NEXT(a_stall_holds, v3_reg && !rdy4, v3_reg && $stable(lane_sum[0]))
    `VT4_ASSERT_NOW(a_ready_chain, v1_reg && v2_reg && v3_reg && !rdy4, !in_item.ready)

endmodule

// ----- hdl/vt4_lane.sv -----
// One row lane: four multiplies, pairwise sum, final sum with saturation.
// Depends on vt4_pkg.
module vt4_lane (
    input  logic                    clk,
    input  vt4_pkg::vt4_lane_ctrl_t ctrl,
    input  vt4_pkg::vt4_word_t      row [vt4_pkg::DIM],
    input  vt4_pkg::vt4_word_t      vec [vt4_pkg::DIM],
    output vt4_pkg::vt4_word_t      sum,
    output logic                    sat
);
    import vt4_pkg::*;

    localparam vt4_sum_t SAT_MAX = SUM_W'(32'sh7fffffff);
    localparam vt4_sum_t SAT_MIN = SUM_W'(32'sh80000000);

    vt4_prod_t prod_reg [DIM];
    vt4_pair_t pair_reg [2];
    vt4_word_t sum_reg;
    logic      sat_reg;

    vt4_term_t term [DIM];
    vt4_sum_t  total;
    vt4_word_t sum_next;
    logic      sat_next;

    always_comb
    begin
        for (int c = 0; c < DIM; c++)
        begin
            term[c] = TERM_W'(prod_reg[c] >>> FRAC_BITS);
        end
        total = SUM_W'(pair_reg[0]) + SUM_W'(pair_reg[1]);
        priority if (total > SAT_MAX)
        begin
            sum_next = WORD_W'(SAT_MAX);
            sat_next = 1'b1;
        end
        else if (total < SAT_MIN)
        begin
            sum_next = WORD_W'(SAT_MIN);
            sat_next = 1'b1;
        end
        else
        begin
            sum_next = WORD_W'(total);
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.en_mul)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                prod_reg[c] <= PROD_W'(row[c]) * PROD_W'(vec[c]);
            end
        end
        if (ctrl.en_pair)
        begin
            pair_reg[0] <= PAIR_W'(term[0]) + PAIR_W'(term[1]);
            pair_reg[1] <= PAIR_W'(term[2]) + PAIR_W'(term[3]);
        end
        if (ctrl.en_sum)
        begin
            sum_reg <= sum_next;
            sat_reg <= sat_next;
        end
    end

    assign sum = sum_reg;
    assign sat = sat_reg;

endmodule

// ----- hdl/vt4_merge.sv -----
// Merge stage: collect the four lane sums, combine saturation flags, output register.
// Depends on vt4_pkg and vt4_if.
module vt4_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  vt4_pkg::vt4_word_t    lane_sum [vt4_pkg::DIM],
    input  logic [vt4_pkg::DIM-1:0] lane_sat,
    vt4_out_if.source             out_item
);
    import vt4_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    logic      load;
    vt4_word_t x_reg, y_reg, z_reg, w_reg;
    logic      sat_reg;

    assign up_ready   = !valid_reg || out_item.ready;
    assign load       = up_ready && up_valid;
    assign valid_next = load || (valid_reg && !out_item.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            x_reg   <= lane_sum[0];
            y_reg   <= lane_sum[1];
            z_reg   <= lane_sum[2];
            w_reg   <= lane_sum[3];
            sat_reg <= |lane_sat;
        end
    end

    assign out_item.valid    = valid_reg;
    assign out_item.out_x    = x_reg;
    assign out_item.out_y    = y_reg;
    assign out_item.out_z    = z_reg;
    assign out_item.out_w    = w_reg;
    assign out_item.sat_flag = sat_reg;

endmodule

// ----- verif/vertex_transform_4x4_test.sv -----
`timescale 1ns / 1ps
// Testbench for vertex_transform_4x4: directed table, then random load/transform traffic.
// Keeps its own Q16.16 matrix and transform predictor; needs vt4_pkg and vt4_if.
module vertex_transform_4x4_test;

    import vt4_pkg::*;

    localparam int      RANDOM_ITEMS   = 1330;
    localparam int      PHASE_ITEMS    = 450;
    localparam int      LONG_HOLD      = 300;
    localparam int      DRAIN_CYCLES   = 16;
    localparam int      TIMEOUT_CYCLES = 400000;
    localparam longint  WORD_HI        = 64'sd2147483647;
    localparam longint  WORD_LO        = -64'sd2147483648;

    localparam vt4_word_t QMAX = 32'sh7FFF_FFFF;
    localparam vt4_word_t QMIN = 32'sh8000_0000;

    typedef struct {
        logic             mode;
        logic [IDX_W-1:0] idx;
        vt4_word_t        value;
        vt4_word_t        x;
        vt4_word_t        y;
        vt4_word_t        z;
        vt4_word_t        w;
    } vertex_item_t;

    typedef struct packed {
        vt4_word_t x;
        vt4_word_t y;
        vt4_word_t z;
        vt4_word_t w;
        logic      sat;
    } vertex_result_t;

    typedef struct {
        vertex_item_t   item;
        bit             typed;
        vertex_result_t res;
    } directed_row_t;

    logic clk;
    logic rst_n;

    vt4_in_if  in_item();
    vt4_out_if out_item();

    vertex_transform_4x4 DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .out_item (out_item)
    );

    vt4_word_t      matrix_shadow[ELEMS];
    vertex_result_t expected_vertices[$];
    directed_row_t  directed_rows[$];

    int  mismatch_count;
    int  cycle_count;
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  long_hold_armed;
    bit  long_hold_done;
    int  hold_left;

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    function automatic vertex_result_t transform_vertex(vt4_word_t vx, vt4_word_t vy,
                                                        vt4_word_t vz, vt4_word_t vw);
        longint         vec[DIM];
        longint         acc;
        vt4_word_t      comp[DIM];
        vertex_result_t res;
        vec[0] = longint'(vx);
        vec[1] = longint'(vy);
        vec[2] = longint'(vz);
        vec[3] = longint'(vw);
        res.sat = 1'b0;
        for (int r = 0; r < DIM; r++)
        begin
            acc = 0;
            for (int c = 0; c < DIM; c++)
                acc += (longint'(matrix_shadow[c*DIM+r]) * vec[c]) >>> FRAC_BITS;
            if (acc > WORD_HI)
            begin
                acc = WORD_HI;
                res.sat = 1'b1;
            end
            else if (acc < WORD_LO)
            begin
                acc = WORD_LO;
                res.sat = 1'b1;
            end
            comp[r] = vt4_word_t'(acc);
        end
        res.x = comp[0];
        res.y = comp[1];
        res.z = comp[2];
        res.w = comp[3];
        return res;
    endfunction

    function automatic vt4_word_t random_q();
        case ($urandom_range(9))
            0, 1, 2, 3: return vt4_word_t'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
            4:          return vt4_word_t'($urandom_range(512)) - 32'sd256;
            5, 6:       return vt4_word_t'($urandom);
            7:          return vt4_word_t'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
            default:
                case ($urandom_range(4))
                    0:       return QMAX;
                    1:       return QMIN;
                    2:       return ONE_Q;
                    3:       return -ONE_Q;
                    default: return '0;
                endcase
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < 50)
            $display("%0t ns: %s mismatch: got %0d, want %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(input vertex_item_t it, input bit typed,
                             input vertex_result_t typed_res);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_item.valid <= 1'b0;
            @(posedge clk);
        end
        in_item.valid      <= 1'b1;
        in_item.mode       <= it.mode;
        in_item.elem_index <= it.idx;
        in_item.elem_value <= it.value;
        in_item.vec_x      <= it.x;
        in_item.vec_y      <= it.y;
        in_item.vec_z      <= it.z;
        in_item.vec_w      <= it.w;
        do
            @(posedge clk);
        while (!in_item.ready);
        if (it.mode == MODE_LOAD)
            matrix_shadow[it.idx] = it.value;
        else if (typed)
            expected_vertices.push_back(typed_res);
        else
            expected_vertices.push_back(transform_vertex(it.x, it.y, it.z, it.w));
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES)
        begin
            $display("vertex_transform_4x4_test: FAIL");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_item.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_item.ready <= 1'b0;
        end
        else if (long_hold_armed && !long_hold_done)
        begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD;
            out_item.ready <= 1'b0;
        end
        else
            out_item.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_results
        vertex_result_t want;
        if (rst_n && out_item.valid && out_item.ready)
        begin
            if (expected_vertices.size() == 0)
                flag_mismatch("unexpected transfer, out_x", longint'(out_item.out_x), 64'sd0);
            else
            begin
                want = expected_vertices.pop_front();
                if (out_item.out_x !== want.x)
                    flag_mismatch("out_x", longint'(out_item.out_x), longint'(want.x));
                if (out_item.out_y !== want.y)
                    flag_mismatch("out_y", longint'(out_item.out_y), longint'(want.y));
                if (out_item.out_z !== want.z)
                    flag_mismatch("out_z", longint'(out_item.out_z), longint'(want.z));
                if (out_item.out_w !== want.w)
                    flag_mismatch("out_w", longint'(out_item.out_w), longint'(want.w));
                if (out_item.sat_flag !== want.sat)
                    flag_mismatch("sat_flag", longint'(out_item.sat_flag), longint'(want.sat));
            end
        end
    end

    initial
    begin : stimulus
        vertex_item_t   it;
        vertex_result_t none;

        none = '0;
        mismatch_count  = 0;
        cycle_count     = 0;
        hold_left       = 0;
        long_hold_armed = 1'b0;
        long_hold_done  = 1'b0;
        send_idle_pct   = 22;
        recv_idle_pct   = 86;
        rst_n = 1'b0;
        in_item.valid      <= 1'b0;
        in_item.mode       <= MODE_LOAD;
        in_item.elem_index <= '0;
        in_item.elem_value <= '0;
        in_item.vec_x      <= '0;
        in_item.vec_y      <= '0;
        in_item.vec_z      <= '0;
        in_item.vec_w      <= '0;

        for (int i = 0; i < ELEMS; i++)
            matrix_shadow[i] = '0;
        for (int i = 0; i < DIM; i++)
            matrix_shadow[i*DIM+i] = ONE_Q;

        // identity after reset, elem fields ignored
        directed_rows.push_back('{'{MODE_TRANSFORM, 4'hF, 32'hFFFF_FFFF,
                                    ONE_Q, -ONE_Q, QMAX, QMIN},
                                  1'b1, '{ONE_Q, -ONE_Q, QMAX, QMIN, 1'b0}});
        // load with vector fields ignored
        directed_rows.push_back('{'{MODE_LOAD, 4'h0, QMAX, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, none});
        directed_rows.push_back('{'{MODE_TRANSFORM, 4'h0, 0, QMAX, 0, 0, 0},
                                  1'b1, '{QMAX, 32'sd0, 32'sd0, 32'sd0, 1'b1}});
        directed_rows.push_back('{'{MODE_TRANSFORM, 4'h0, 0, QMIN, 0, 0, 0},
                                  1'b1, '{QMIN, 32'sd0, 32'sd0, 32'sd0, 1'b1}});
        directed_rows.push_back('{'{MODE_LOAD, 4'h0, QMIN, 0, 0, 0, 0}, 1'b0, none});
        directed_rows.push_back('{'{MODE_TRANSFORM, 4'h0, 0, QMIN, 0, 0, 0},
                                  1'b1, '{QMAX, 32'sd0, 32'sd0, 32'sd0, 1'b1}});
        directed_rows.push_back('{'{MODE_TRANSFORM, 4'h0, 0, 0, 0, 0, 0},
                                  1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0}});
        directed_rows.push_back('{'{MODE_LOAD, 4'h0, ONE_Q, 0, 0, 0, 0}, 1'b0, none});
        directed_rows.push_back('{'{MODE_LOAD, 4'h5, 32'sd1, 0, 0, 0, 0}, 1'b0, none});
        // negative product rounds toward minus infinity
        directed_rows.push_back('{'{MODE_TRANSFORM, 4'h0, 0, 0, -32'sd1, 0, 0},
                                  1'b1, '{32'sd0, -32'sd1, 32'sd0, 32'sd0, 1'b0}});
        directed_rows.push_back('{'{MODE_TRANSFORM, 4'h0, 0, 0, 32'sd1, 0, 0},
                                  1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0}});
        // row sum overflows although each product fits
        directed_rows.push_back('{'{MODE_LOAD, 4'hC, ONE_Q, 0, 0, 0, 0}, 1'b0, none});
        directed_rows.push_back('{'{MODE_TRANSFORM, 4'h0, 0, QMAX, 0, 0, QMAX},
                                  1'b1, '{QMAX, 32'sd0, 32'sd0, QMAX, 1'b1}});
        directed_rows.push_back('{'{MODE_TRANSFORM, 4'h0, 0, QMIN, 0, 0, QMIN},
                                  1'b1, '{QMIN, 32'sd0, 32'sd0, QMIN, 1'b1}});
        directed_rows.push_back('{'{MODE_LOAD, 4'h3, 32'h1234_5678, 0, 0, 0, 0}, 1'b0, none});
        directed_rows.push_back('{'{MODE_LOAD, 4'hA, 32'hFFFF_8000, 0, 0, 0, 0}, 1'b0, none});
        directed_rows.push_back('{'{MODE_LOAD, 4'h6, 32'hFFFF_FFFF, 0, 0, 0, 0}, 1'b0, none});
        directed_rows.push_back('{'{MODE_LOAD, 4'hF, 32'h0000_8000, 0, 0, 0, 0}, 1'b0, none});
        directed_rows.push_back('{'{MODE_TRANSFORM, 4'h0, 0, 32'h0003_0000, 32'hFFFE_8000,
                                    32'h7FFF_0000, 32'h8001_0000}, 1'b0, none});
        directed_rows.push_back('{'{MODE_TRANSFORM, 4'h9, 32'h5555_5555, 32'hDEAD_BEEF,
                                    32'h0000_FFFF, 32'hFFFF_0001, 32'h2AAA_AAAA}, 1'b0, none});
        directed_rows.push_back('{'{MODE_TRANSFORM, 4'h0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                    32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, none});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == PHASE_ITEMS)
            begin
                send_idle_pct = 86;
                recv_idle_pct = 22;
            end
            else if (n == 2 * PHASE_ITEMS)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                long_hold_armed = 1'b1;
            end
            it.mode  = ($urandom_range(99) < 30) ? MODE_LOAD : MODE_TRANSFORM;
            it.idx   = IDX_W'($urandom_range(ELEMS - 1));
            it.value = random_q();
            it.x     = random_q();
            it.y     = random_q();
            it.z     = random_q();
            it.w     = random_q();
            send_item(it, 1'b0, none);
        end
        in_item.valid <= 1'b0;

        while (expected_vertices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("vertex_transform_4x4_test: PASS");
        else
            $display("vertex_transform_4x4_test: FAIL");
        $finish;
    end

endmodule

// ----- vertex_transform_4x4.f -----
+incdir+hdl
hdl/vt4_pkg.sv
hdl/vt4_if.sv
hdl/vt4_lane.sv
hdl/vt4_merge.sv
hdl/vertex_transform_4x4.sv
verif/vertex_transform_4x4_test.sv
